/* design/dinic_max_flow_defines.svh */
// Assertion macros shared by the maximum flow design.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DINIC_MAX_FLOW_DEFINES_SVH
`define DINIC_MAX_FLOW_DEFINES_SVH
`ifndef SYNTHESIS
`define DMF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DMF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> expr) else $error(msg);
`else
`define DMF_ASSERT(label, clk, rst, prop, msg)
`define DMF_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

/* design/dmf_pkg.sv */
// Package for the maximum flow design: widths, codes, states and the config struct.
// No dependencies.
`timescale 1ns / 1ps
package dmf_pkg;
  localparam int NODE_W = 6;
  localparam int MAX_NODES = 64;
  localparam int LVL_W = 7;
  localparam int NCNT_W = 7;
  localparam int FLOW_W = 40;
  localparam int CFG_W = 7;
  localparam int IN_CAP_W = 32;
  localparam int DEF_MAX_EDGES = 256;
  localparam int DEF_CAP_BITS = 32;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_SOURCE     = 2'd1,
    REG_SINK       = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BFS_INIT,
    S_BFS_SEED,
    S_BFS_POP,
    S_BFS_U,
    S_BFS_LU,
    S_BFS_SCAN,
    S_BFS_EDGE,
    S_BFS_LV,
    S_BFS_END,
    S_BFS_CHK,
    S_DFS_INIT,
    S_DFS_NODE,
    S_DFS_LOAD,
    S_DFS_SCAN,
    S_DFS_EDGE,
    S_DFS_LV,
    S_DFS_DEC,
    S_DFS_POP,
    S_DFS_POPE,
    S_AUG_MRD,
    S_AUG_MROW,
    S_AUG_MIN,
    S_AUG_ARD,
    S_AUG_AROW,
    S_AUG_SUB,
    S_AUG_ADD,
    S_AUG_SUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [NCNT_W-1:0] n;
    logic [NODE_W-1:0] s;
    logic [NODE_W-1:0] t;
  } cfg_t;
endpackage

/* design/dmf_ifs.sv */
// Request channels of the maximum flow design: edge input and flow result.
// Depends on dmf_pkg for field widths.
`timescale 1ns / 1ps
interface dmf_edge_if;
  logic valid;
  logic ready;
  logic [dmf_pkg::NODE_W-1:0] from_node;
  logic [dmf_pkg::NODE_W-1:0] to_node;
  logic [dmf_pkg::IN_CAP_W-1:0] capacity;
  logic last_edge;
  modport source (output valid, from_node, to_node, capacity, last_edge, input ready);
  modport sink (input valid, from_node, to_node, capacity, last_edge, output ready);
endinterface

interface dmf_result_if;
  logic valid;
  logic ready;
  logic [dmf_pkg::FLOW_W-1:0] total_flow;
  logic dropped_edges;
  modport source (output valid, total_flow, dropped_edges, input ready);
  modport sink (input valid, total_flow, dropped_edges, output ready);
endinterface

/* design/dmf_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module dmf_ram #(
  parameter int W = 8,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/dmf_alu.sv */
// Shared add and subtract unit of the flow sequencer.
// Depends on dmf_pkg for the operation codes.
`timescale 1ns / 1ps
module dmf_alu #(
  parameter int W = 40
) (
  input  dmf_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y,
  output logic             borrow
);
  logic [W:0] full;

  always_comb begin
    case (op)
      dmf_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      dmf_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      default:          full = '0;
    endcase
    y = full[W-1:0];
    borrow = (op == dmf_pkg::ALU_SUB) && full[W];
  end
endmodule

/* design/dmf_ctrl.sv */
// Sequencer of the maximum flow design: edge loading, level building,
// blocking-flow pushes and augmentation. Depends on dmf_pkg, dmf_ifs, dmf_ram, dmf_alu.
`timescale 1ns / 1ps
`include "dinic_max_flow_defines.svh"
module dmf_ctrl #(
  parameter int MAX_EDGES = dmf_pkg::DEF_MAX_EDGES,
  parameter int CAP_BITS = dmf_pkg::DEF_CAP_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  dmf_pkg::cfg_t  cfg,
  dmf_edge_if.sink       edges,
  dmf_result_if.source   results
);
  localparam int ROW_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ROWC_W = $clog2(MAX_EDGES + 1);
  localparam int CNT_W = ROWC_W + 1;
  localparam int K_W = ROW_AW + 1;
  localparam int NW = dmf_pkg::NODE_W;
  localparam int EW = 2 * NW + CAP_BITS;
  localparam int ALU_W = (CAP_BITS + 1 > dmf_pkg::FLOW_W) ? CAP_BITS + 1 : dmf_pkg::FLOW_W;
  localparam int LW = dmf_pkg::LVL_W;
  localparam int CW = dmf_pkg::NCNT_W;

  dmf_pkg::state_t state, state_next;
  logic [CW-1:0] i, i_next, qh, qh_next, qt, qt_next, depth, depth_next, sidx, sidx_next;
  logic [NW-1:0] u, u_next, v, v_next;
  logic [LW-1:0] lu, lu_next;
  logic [CNT_W-1:0] k, k_next;
  logic [K_W-1:0] kk, kk_next;
  logic found, found_next;
  logic [CAP_BITS-1:0] bneck, bneck_next;
  logic [dmf_pkg::FLOW_W-1:0] flow_sum, flow_sum_next, out_total, out_total_next;
  logic [EW-1:0] ent, ent_next, own_w, own_w_next, twin_w, twin_w_next;
  logic [ROWC_W-1:0] rows, rows_next;
  logic drop, drop_next, out_valid, out_valid_next, out_drop, out_drop_next;

  logic lvl_we;
  logic [NW-1:0] lvl_waddr, lvl_raddr;
  logic [LW-1:0] lvl_wdata, lvl_rdata;
  logic ptr_we;
  logic [NW-1:0] ptr_waddr, ptr_raddr;
  logic [CNT_W-1:0] ptr_wdata, ptr_rdata;
  logic que_we;
  logic [NW-1:0] que_waddr, que_raddr, que_wdata, que_rdata;
  logic stk_we;
  logic [NW-1:0] stk_waddr, stk_raddr;
  logic [K_W-1:0] stk_wdata, stk_rdata;
  logic e0_we, e1_we;
  logic [ROW_AW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e0_wdata, e1_wdata, e0_rdata, e1_rdata;

  dmf_pkg::alu_op_t alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic alu_borrow;

  logic [EW-1:0] sel_w, own_r, twin_r;
  logic [NW-1:0] tl, hd;
  logic [CAP_BITS-1:0] rs, own_res, twin_res;
  logic [CNT_W-1:0] etot;
  logic head_ok;

  dmf_ram #(.W(LW), .AW(NW)) u_lvl (
    .clk, .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata), .raddr(lvl_raddr),
    .rdata(lvl_rdata));
  dmf_ram #(.W(CNT_W), .AW(NW)) u_ptr (
    .clk, .we(ptr_we), .waddr(ptr_waddr), .wdata(ptr_wdata), .raddr(ptr_raddr),
    .rdata(ptr_rdata));
  dmf_ram #(.W(NW), .AW(NW)) u_que (
    .clk, .we(que_we), .waddr(que_waddr), .wdata(que_wdata), .raddr(que_raddr),
    .rdata(que_rdata));
  dmf_ram #(.W(K_W), .AW(NW)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata), .raddr(stk_raddr),
    .rdata(stk_rdata));
  dmf_ram #(.W(EW), .AW(ROW_AW)) u_even (
    .clk, .we(e0_we), .waddr(e_waddr), .wdata(e0_wdata), .raddr(e_raddr),
    .rdata(e0_rdata));
  dmf_ram #(.W(EW), .AW(ROW_AW)) u_odd (
    .clk, .we(e1_we), .waddr(e_waddr), .wdata(e1_wdata), .raddr(e_raddr),
    .rdata(e1_rdata));

  dmf_alu #(.W(ALU_W)) u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .borrow(alu_borrow));

  assign sel_w = k[0] ? e1_rdata : e0_rdata;
  assign tl = sel_w[EW-1 -: NW];
  assign hd = sel_w[EW-NW-1 -: NW];
  assign rs = sel_w[CAP_BITS-1:0];
  assign own_r = kk[0] ? e1_rdata : e0_rdata;
  assign twin_r = kk[0] ? e0_rdata : e1_rdata;
  assign own_res = own_r[CAP_BITS-1:0];
  assign twin_res = twin_w[CAP_BITS-1:0];
  assign etot = {rows, 1'b0};
  assign head_ok = {1'b0, hd} < cfg.n;

  assign results.valid = out_valid;
  assign results.total_flow = out_total;
  assign results.dropped_edges = out_drop;

  always_comb begin
    state_next = state;
    i_next = i;
    qh_next = qh;
    qt_next = qt;
    depth_next = depth;
    sidx_next = sidx;
    u_next = u;
    v_next = v;
    lu_next = lu;
    k_next = k;
    kk_next = kk;
    found_next = found;
    bneck_next = bneck;
    flow_sum_next = flow_sum;
    ent_next = ent;
    own_w_next = own_w;
    twin_w_next = twin_w;
    rows_next = rows;
    drop_next = drop;
    out_valid_next = out_valid && !results.ready;
    out_total_next = out_total;
    out_drop_next = out_drop;
    edges.ready = 1'b0;
    lvl_we = 1'b0;
    lvl_waddr = '0;
    lvl_wdata = '0;
    lvl_raddr = '0;
    ptr_we = 1'b0;
    ptr_waddr = '0;
    ptr_wdata = '0;
    ptr_raddr = '0;
    que_we = 1'b0;
    que_waddr = '0;
    que_wdata = '0;
    que_raddr = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    e0_we = 1'b0;
    e1_we = 1'b0;
    e_waddr = '0;
    e0_wdata = '0;
    e1_wdata = '0;
    e_raddr = '0;
    alu_op = dmf_pkg::ALU_ADD;
    alu_a = '0;
    alu_b = '0;

    case (state)
      dmf_pkg::S_IDLE: begin
        edges.ready = 1'b1;
        if (edges.valid) begin
          if ({1'b0, edges.from_node} >= cfg.n || {1'b0, edges.to_node} >= cfg.n) begin
            drop_next = 1'b1;
          end else if (edges.from_node != edges.to_node) begin
            if (rows == ROWC_W'(MAX_EDGES)) begin
              drop_next = 1'b1;
            end else begin
              e0_we = 1'b1;
              e1_we = 1'b1;
              e_waddr = rows[ROW_AW-1:0];
              e0_wdata = {edges.from_node, edges.to_node, CAP_BITS'(edges.capacity)};
              e1_wdata = {edges.to_node, edges.from_node, {CAP_BITS{1'b0}}};
              rows_next = rows + 1'b1;
            end
          end
          if (edges.last_edge) begin
            flow_sum_next = '0;
            i_next = '0;
            if (cfg.s != cfg.t && {1'b0, cfg.s} < cfg.n && {1'b0, cfg.t} < cfg.n) begin
              state_next = dmf_pkg::S_BFS_INIT;
            end else begin
              state_next = dmf_pkg::S_DONE;
            end
          end
        end
      end
      dmf_pkg::S_BFS_INIT: begin
        lvl_we = 1'b1;
        lvl_waddr = i[NW-1:0];
        lvl_wdata = cfg.n + 1'b1;
        i_next = i + 1'b1;
        if (i == cfg.n - 1'b1) begin
          state_next = dmf_pkg::S_BFS_SEED;
        end
      end
      dmf_pkg::S_BFS_SEED: begin
        lvl_we = 1'b1;
        lvl_waddr = cfg.s;
        que_we = 1'b1;
        que_wdata = cfg.s;
        qh_next = '0;
        qt_next = CW'(1);
        state_next = dmf_pkg::S_BFS_POP;
      end
      dmf_pkg::S_BFS_POP: begin
        if (qh < qt) begin
          que_raddr = qh[NW-1:0];
          qh_next = qh + 1'b1;
          state_next = dmf_pkg::S_BFS_U;
        end else begin
          state_next = dmf_pkg::S_BFS_END;
        end
      end
      dmf_pkg::S_BFS_U: begin
        u_next = que_rdata;
        lvl_raddr = que_rdata;
        state_next = (que_rdata == cfg.t) ? dmf_pkg::S_BFS_END : dmf_pkg::S_BFS_LU;
      end
      dmf_pkg::S_BFS_LU: begin
        lu_next = lvl_rdata;
        k_next = '0;
        state_next = dmf_pkg::S_BFS_SCAN;
      end
      dmf_pkg::S_BFS_SCAN: begin
        if (k < etot) begin
          e_raddr = k[ROW_AW:1];
          state_next = dmf_pkg::S_BFS_EDGE;
        end else begin
          state_next = dmf_pkg::S_BFS_POP;
        end
      end
      dmf_pkg::S_BFS_EDGE: begin
        if (tl == u && head_ok && rs != '0) begin
          lvl_raddr = hd;
          v_next = hd;
          state_next = dmf_pkg::S_BFS_LV;
        end else begin
          k_next = k + 1'b1;
          state_next = dmf_pkg::S_BFS_SCAN;
        end
      end
      dmf_pkg::S_BFS_LV: begin
        if ({1'b0, lvl_rdata} > {1'b0, lu} + 8'd1) begin
          lvl_we = 1'b1;
          lvl_waddr = v;
          lvl_wdata = lu + 1'b1;
          if (qt < CW'(dmf_pkg::MAX_NODES)) begin
            que_we = 1'b1;
            que_waddr = qt[NW-1:0];
            que_wdata = v;
            qt_next = qt + 1'b1;
          end
        end
        k_next = k + 1'b1;
        state_next = dmf_pkg::S_BFS_SCAN;
      end
      dmf_pkg::S_BFS_END: begin
        lvl_raddr = cfg.t;
        state_next = dmf_pkg::S_BFS_CHK;
      end
      dmf_pkg::S_BFS_CHK: begin
        i_next = '0;
        if (lvl_rdata != cfg.n + 1'b1) begin
          state_next = dmf_pkg::S_DFS_INIT;
        end else begin
          state_next = dmf_pkg::S_DONE;
        end
      end
      dmf_pkg::S_DFS_INIT: begin
        ptr_we = 1'b1;
        ptr_waddr = i[NW-1:0];
        i_next = i + 1'b1;
        if (i == cfg.n - 1'b1) begin
          depth_next = '0;
          u_next = cfg.s;
          state_next = dmf_pkg::S_DFS_NODE;
        end
      end
      dmf_pkg::S_DFS_NODE: begin
        ptr_raddr = u;
        lvl_raddr = u;
        state_next = dmf_pkg::S_DFS_LOAD;
      end
      dmf_pkg::S_DFS_LOAD: begin
        k_next = ptr_rdata;
        lu_next = lvl_rdata;
        state_next = dmf_pkg::S_DFS_SCAN;
      end
      dmf_pkg::S_DFS_SCAN: begin
        if (k < etot) begin
          e_raddr = k[ROW_AW:1];
          state_next = dmf_pkg::S_DFS_EDGE;
        end else begin
          found_next = 1'b0;
          state_next = dmf_pkg::S_DFS_DEC;
        end
      end
      dmf_pkg::S_DFS_EDGE: begin
        ent_next = sel_w;
        if (tl == u && head_ok) begin
          lvl_raddr = hd;
          state_next = dmf_pkg::S_DFS_LV;
        end else begin
          k_next = k + 1'b1;
          state_next = dmf_pkg::S_DFS_SCAN;
        end
      end
      dmf_pkg::S_DFS_LV: begin
        if (lvl_rdata == lu + 1'b1 && ent[CAP_BITS-1:0] != '0) begin
          found_next = 1'b1;
          state_next = dmf_pkg::S_DFS_DEC;
        end else begin
          k_next = k + 1'b1;
          state_next = dmf_pkg::S_DFS_SCAN;
        end
      end
      dmf_pkg::S_DFS_DEC: begin
        ptr_we = 1'b1;
        ptr_waddr = u;
        ptr_wdata = k;
        if (found && depth < CW'(dmf_pkg::MAX_NODES)) begin
          stk_we = 1'b1;
          stk_waddr = depth[NW-1:0];
          stk_wdata = k[K_W-1:0];
          depth_next = depth + 1'b1;
          if (ent[EW-NW-1 -: NW] == cfg.t) begin
            sidx_next = '0;
            state_next = dmf_pkg::S_AUG_MRD;
          end else begin
            u_next = ent[EW-NW-1 -: NW];
            state_next = dmf_pkg::S_DFS_NODE;
          end
        end else if (depth == '0) begin
          i_next = '0;
          state_next = dmf_pkg::S_BFS_INIT;
        end else begin
          depth_next = depth - 1'b1;
          stk_raddr = NW'(depth - 1'b1);
          state_next = dmf_pkg::S_DFS_POP;
        end
      end
      dmf_pkg::S_DFS_POP: begin
        k_next = CNT_W'(stk_rdata);
        e_raddr = stk_rdata[K_W-1:1];
        state_next = dmf_pkg::S_DFS_POPE;
      end
      dmf_pkg::S_DFS_POPE: begin
        u_next = tl;
        ptr_we = 1'b1;
        ptr_waddr = tl;
        ptr_wdata = k + 1'b1;
        state_next = dmf_pkg::S_DFS_NODE;
      end
      dmf_pkg::S_AUG_MRD: begin
        stk_raddr = sidx[NW-1:0];
        state_next = dmf_pkg::S_AUG_MROW;
      end
      dmf_pkg::S_AUG_MROW: begin
        kk_next = stk_rdata;
        e_raddr = stk_rdata[K_W-1:1];
        state_next = dmf_pkg::S_AUG_MIN;
      end
      dmf_pkg::S_AUG_MIN: begin
        alu_op = dmf_pkg::ALU_SUB;
        alu_a = ALU_W'(own_res);
        alu_b = ALU_W'(bneck);
        if (sidx == '0 || alu_borrow) begin
          bneck_next = own_res;
        end
        if (sidx + 1'b1 == depth) begin
          sidx_next = '0;
          state_next = dmf_pkg::S_AUG_ARD;
        end else begin
          sidx_next = sidx + 1'b1;
          state_next = dmf_pkg::S_AUG_MRD;
        end
      end
      dmf_pkg::S_AUG_ARD: begin
        stk_raddr = sidx[NW-1:0];
        state_next = dmf_pkg::S_AUG_AROW;
      end
      dmf_pkg::S_AUG_AROW: begin
        kk_next = stk_rdata;
        e_raddr = stk_rdata[K_W-1:1];
        state_next = dmf_pkg::S_AUG_SUB;
      end
      dmf_pkg::S_AUG_SUB: begin
        alu_op = dmf_pkg::ALU_SUB;
        alu_a = ALU_W'(own_res);
        alu_b = ALU_W'(bneck);
        own_w_next = {own_r[EW-1:CAP_BITS], alu_y[CAP_BITS-1:0]};
        twin_w_next = twin_r;
        state_next = dmf_pkg::S_AUG_ADD;
      end
      dmf_pkg::S_AUG_ADD: begin
        alu_op = dmf_pkg::ALU_ADD;
        alu_a = ALU_W'(twin_res);
        alu_b = ALU_W'(bneck);
        e0_we = 1'b1;
        e1_we = 1'b1;
        e_waddr = kk[K_W-1:1];
        if (kk[0]) begin
          e1_wdata = own_w;
          e0_wdata = {twin_w[EW-1:CAP_BITS], alu_y[CAP_BITS-1:0]};
        end else begin
          e0_wdata = own_w;
          e1_wdata = {twin_w[EW-1:CAP_BITS], alu_y[CAP_BITS-1:0]};
        end
        if (sidx + 1'b1 == depth) begin
          state_next = dmf_pkg::S_AUG_SUM;
        end else begin
          sidx_next = sidx + 1'b1;
          state_next = dmf_pkg::S_AUG_ARD;
        end
      end
      dmf_pkg::S_AUG_SUM: begin
        alu_op = dmf_pkg::ALU_ADD;
        alu_a = ALU_W'(flow_sum);
        alu_b = ALU_W'(bneck);
        flow_sum_next = alu_y[dmf_pkg::FLOW_W-1:0];
        depth_next = '0;
        u_next = cfg.s;
        state_next = dmf_pkg::S_DFS_NODE;
      end
      dmf_pkg::S_DONE: begin
        if (!out_valid || results.ready) begin
          out_valid_next = 1'b1;
          out_total_next = flow_sum;
          out_drop_next = drop;
          rows_next = '0;
          drop_next = 1'b0;
          state_next = dmf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dmf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmf_pkg::S_IDLE;
      rows <= '0;
      drop <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rows <= rows_next;
      drop <= drop_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    qh <= qh_next;
    qt <= qt_next;
    depth <= depth_next;
    sidx <= sidx_next;
    u <= u_next;
    v <= v_next;
    lu <= lu_next;
    k <= k_next;
    kk <= kk_next;
    found <= found_next;
    bneck <= bneck_next;
    flow_sum <= flow_sum_next;
    ent <= ent_next;
    own_w <= own_w_next;
    twin_w <= twin_w_next;
    out_total <= out_total_next;
    out_drop <= out_drop_next;
  end

  `DMF_ASSERT(a_rows_bound, clk, rst, rows <= ROWC_W'(MAX_EDGES), "edge store overfilled")
  `DMF_ASSERT(a_aug_path, clk, rst, (state == dmf_pkg::S_AUG_MRD) |-> (depth != '0), "empty path")
  `DMF_ASSERT(a_queue_order, clk, rst, (state == dmf_pkg::S_BFS_POP) |-> (qh <= qt), "queue underrun")
  `DMF_ASSERT(a_out_rise, clk, rst, $rose(out_valid) |-> ($past(state) == dmf_pkg::S_DONE), "stray result")
  `DMF_ASSERT_NEXT(a_last_starts, clk, rst, edges.valid && edges.ready && edges.last_edge, state != dmf_pkg::S_IDLE, "last edge ignored")
endmodule

/* design/dinic_max_flow.sv */
// Maximum flow block (Dinic's method) with configuration registers and sequencer.
// Edges load at one request per cycle while the block is idle; the last edge starts a
// computation whose length follows the graph: each level pass clears the levels of all n
// nodes and scans every stored edge per dequeued node, and each push scans stored edges.
// Reset is synchronous and active high; it empties the edge store and restores the registers.
`timescale 1ns / 1ps
module dinic_max_flow #(
  parameter int MAX_EDGES = dmf_pkg::DEF_MAX_EDGES,
  parameter int CAP_BITS = dmf_pkg::DEF_CAP_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [dmf_pkg::CFG_W-1:0] cfg_data,
  dmf_edge_if.sink                  edges,
  dmf_result_if.source              results
);
  logic [dmf_pkg::NCNT_W-1:0] node_count;
  logic [dmf_pkg::NODE_W-1:0] source_node;
  logic [dmf_pkg::NODE_W-1:0] sink_node;
  dmf_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dmf_pkg::NCNT_W'(dmf_pkg::MAX_NODES);
      source_node <= '0;
      sink_node <= dmf_pkg::NODE_W'(1);
    end else if (cfg_we) begin
      case (dmf_pkg::reg_idx_t'(cfg_addr))
        dmf_pkg::REG_NODE_COUNT: node_count <= cfg_data;
        dmf_pkg::REG_SOURCE:     source_node <= cfg_data[dmf_pkg::NODE_W-1:0];
        dmf_pkg::REG_SINK:       sink_node <= cfg_data[dmf_pkg::NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.n = (node_count > dmf_pkg::NCNT_W'(dmf_pkg::MAX_NODES)) ?
            dmf_pkg::NCNT_W'(dmf_pkg::MAX_NODES) : node_count;
    cfg.s = source_node;
    cfg.t = sink_node;
  end

  dmf_ctrl #(.MAX_EDGES(MAX_EDGES), .CAP_BITS(CAP_BITS)) u_ctrl (
    .clk,
    .rst,
    .cfg,
    .edges,
    .results
  );
endmodule
